/* rtl/bmhq_pkg.sv */
// Package for the binary min-heap queue: sizes, op and status codes, FSM states.
// No dependencies.
`default_nettype none
package bmhq_pkg;
	localparam int Depth = 64;
	localparam int KeyWidth = 32;
	localparam int TagWidth = 16;
	localparam int AddrWidth = $clog2(Depth);
	localparam int CountWidth = $clog2(Depth + 1);
	localparam int IdxWidth = AddrWidth + 2;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_REQUEUE = 2'd2,
		OP_FIND = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_BADIDX = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_TAIL_RD,
		S_TAIL_GET,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_PLACE,
		S_FIND,
		S_HEAD_RD,
		S_HEAD_GET,
		S_DONE
	} state_t;

	typedef struct packed {
		logic we;
		logic [AddrWidth-1:0] waddr;
		logic [KeyWidth-1:0] wkey;
		logic [TagWidth-1:0] wtag;
		logic [AddrWidth-1:0] raddr;
	} mem_req_t;
endpackage
`default_nettype wire

/* rtl/binary_min_heap_queue_unit.sv */
// Binary min-heap priority queue top level.
// Depends on bmhq_pkg, bmhq_store, bmhq_tag_cam.
`default_nettype none
// One-based min-heap of up to 64 (key, tag) entries held in a synchronous RAM
// with one registered read port. The block works on one item at a time. After
// acceptance it steps through these states before the result appears:
// - full insert or bad index: head read only
// - find: tag compare, then head read
// - insert: a read and a compare per level climbed, at most six levels
// - remove and requeue: both start with a read of
//   the tail entry (remove) or the tag at the index (requeue). They then sift
//   down with a left read, right read and compare/move per level.
// The single read port sets these steps. Find compares all tags at once
// against a flop shadow of the tag store. Every item yields one result with
// status, found index, count and the head entry. The result sits in an output
// register until it is taken. The block then returns to idle, where it
// accepts the next item; it takes no new item while one is in progress.
module binary_min_heap_queue_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] op,
	input wire logic [31:0] key,
	input wire logic [15:0] tag,
	input wire logic [6:0] position,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] status,
	output logic [6:0] found_index,
	output logic [6:0] count,
	output logic [31:0] head_key,
	output logic [15:0] head_tag
);
	localparam int AW = bmhq_pkg::AddrWidth;
	localparam int CW = bmhq_pkg::CountWidth;
	localparam int IW = bmhq_pkg::IdxWidth;
	localparam int KW = bmhq_pkg::KeyWidth;
	localparam int TW = bmhq_pkg::TagWidth;

	bmhq_pkg::state_t state_q, state_d;
	bmhq_pkg::mem_req_t req;
	logic [KW-1:0] rkey;
	logic [TW-1:0] rtag;
	logic [CW-1:0] cnt_q, hit_idx;
	logic [IW-1:0] hole_q;
	logic [KW-1:0] mkey_q, lkey_q;
	logic [TW-1:0] mtag_q, ltag_q;
	logic [1:0] op_q;
	logic [TW-1:0] stag_q;
	logic [1:0] st_q;
	logic [CW-1:0] fidx_q;
	logic [KW-1:0] head_key_q;
	logic [TW-1:0] head_tag_q;
	logic [IW-1:0] child, parent;
	logic has_right, right_wins;

	bmhq_store u_store (.clk(clk), .req(req), .rkey(rkey), .rtag(rtag));
	bmhq_tag_cam u_cam (.clk(clk), .we(req.we), .waddr(req.waddr), .wtag(req.wtag),
		.stag(stag_q), .cnt(cnt_q), .hit_idx(hit_idx));

	assign child = {hole_q[IW-2:0], 1'b0};
	assign parent = hole_q >> 1;
	assign has_right = (child + IW'(1)) <= IW'(cnt_q);
	assign right_wins = has_right && (rkey < lkey_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmhq_pkg::S_IDLE: if (in_valid) begin
				unique case (bmhq_pkg::op_t'(op))
					bmhq_pkg::OP_INSERT:
						state_d = (cnt_q >= CW'(bmhq_pkg::Depth)) ? bmhq_pkg::S_HEAD_RD
							: bmhq_pkg::S_UP_RD;
					bmhq_pkg::OP_REMOVE, bmhq_pkg::OP_REQUEUE:
						state_d = (position == 7'd0 || CW'(position) > cnt_q
							|| position > 7'(bmhq_pkg::Depth)) ? bmhq_pkg::S_HEAD_RD
							: bmhq_pkg::S_TAIL_RD;
					default: state_d = bmhq_pkg::S_FIND;
				endcase
			end
			bmhq_pkg::S_UP_RD:
				state_d = (hole_q > IW'(1)) ? bmhq_pkg::S_UP_CMP : bmhq_pkg::S_PLACE;
			bmhq_pkg::S_UP_CMP:
				state_d = (mkey_q < rkey) ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_PLACE;
			bmhq_pkg::S_TAIL_RD: state_d = bmhq_pkg::S_TAIL_GET;
			bmhq_pkg::S_TAIL_GET:
				state_d = (hole_q <= IW'(cnt_q)) ? bmhq_pkg::S_DN_RDL : bmhq_pkg::S_HEAD_RD;
			bmhq_pkg::S_DN_RDL:
				state_d = (child > IW'(cnt_q)) ? bmhq_pkg::S_PLACE : bmhq_pkg::S_DN_RDR;
			bmhq_pkg::S_DN_RDR: state_d = bmhq_pkg::S_DN_CMP;
			bmhq_pkg::S_DN_CMP:
				state_d = (mkey_q < (right_wins ? rkey : lkey_q)) ? bmhq_pkg::S_PLACE
					: bmhq_pkg::S_DN_RDL;
			bmhq_pkg::S_PLACE: state_d = bmhq_pkg::S_HEAD_RD;
			bmhq_pkg::S_FIND: state_d = bmhq_pkg::S_HEAD_RD;
			bmhq_pkg::S_HEAD_RD: state_d = bmhq_pkg::S_HEAD_GET;
			bmhq_pkg::S_HEAD_GET: state_d = bmhq_pkg::S_DONE;
			bmhq_pkg::S_DONE: if (out_ready) state_d = bmhq_pkg::S_IDLE;
			default: state_d = bmhq_pkg::S_IDLE;
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		req = '0;
		req.wkey = mkey_q;
		req.wtag = mtag_q;
		in_ready = (state_q == bmhq_pkg::S_IDLE);
		out_valid = (state_q == bmhq_pkg::S_DONE);
		unique case (state_q)
			bmhq_pkg::S_UP_RD: req.raddr = AW'(parent - IW'(1));
			bmhq_pkg::S_UP_CMP: if (mkey_q < rkey) begin
				// parent moves down into the hole
				req.we = 1'b1;
				req.waddr = AW'(hole_q - IW'(1));
				req.wkey = rkey;
				req.wtag = rtag;
			end
			// remove reads the tail entry, requeue the tag it keeps
			bmhq_pkg::S_TAIL_RD:
				req.raddr = (op_q == bmhq_pkg::OP_REMOVE) ? AW'(cnt_q - CW'(1))
					: AW'(hole_q - IW'(1));
			bmhq_pkg::S_DN_RDL: req.raddr = AW'(child - IW'(1));
			bmhq_pkg::S_DN_RDR: req.raddr = AW'(child);
			bmhq_pkg::S_DN_CMP: if (!(mkey_q < (right_wins ? rkey : lkey_q))) begin
				req.we = 1'b1;
				req.waddr = AW'(hole_q - IW'(1));
				req.wkey = right_wins ? rkey : lkey_q;
				req.wtag = right_wins ? rtag : ltag_q;
			end
			bmhq_pkg::S_PLACE: begin
				req.we = 1'b1;
				req.waddr = AW'(hole_q - IW'(1));
			end
			default: req.raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bmhq_pkg::S_IDLE && in_valid && state_d == bmhq_pkg::S_UP_RD)
				cnt_q <= cnt_q + CW'(1);
			if (state_q == bmhq_pkg::S_TAIL_RD && op_q == bmhq_pkg::OP_REMOVE)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bmhq_pkg::S_IDLE: if (in_valid) begin
				op_q <= op;
				stag_q <= tag;
				mkey_q <= key;
				mtag_q <= tag;
				fidx_q <= '0;
				st_q <= bmhq_pkg::ST_OK;
				hole_q <= (bmhq_pkg::op_t'(op) == bmhq_pkg::OP_INSERT)
					? IW'(cnt_q) + IW'(1) : IW'(position);
				if (state_d == bmhq_pkg::S_HEAD_RD)
					st_q <= (bmhq_pkg::op_t'(op) == bmhq_pkg::OP_INSERT)
						? bmhq_pkg::ST_FULL : bmhq_pkg::ST_BADIDX;
			end
			bmhq_pkg::S_UP_CMP: if (mkey_q < rkey) hole_q <= parent;
			bmhq_pkg::S_TAIL_GET: begin
				// requeue keeps its new key and takes the stored tag
				if (op_q == bmhq_pkg::OP_REMOVE) mkey_q <= rkey;
				mtag_q <= rtag;
			end
			bmhq_pkg::S_DN_RDR: begin
				lkey_q <= rkey;
				ltag_q <= rtag;
			end
			bmhq_pkg::S_DN_CMP: if (!(mkey_q < (right_wins ? rkey : lkey_q)))
				hole_q <= right_wins ? child + IW'(1) : child;
			bmhq_pkg::S_FIND: begin
				fidx_q <= hit_idx;
				if (hit_idx == '0) st_q <= bmhq_pkg::ST_NOTFOUND;
			end
			bmhq_pkg::S_HEAD_GET: begin
				head_key_q <= (cnt_q == '0) ? '0 : rkey;
				head_tag_q <= (cnt_q == '0) ? '0 : rtag;
			end
			default: begin end
		endcase
	end

	assign status = st_q;
	assign found_index = 7'(fidx_q);
	assign count = 7'(cnt_q);
	assign head_key = head_key_q;
	assign head_tag = head_tag_q;

`ifndef ASSERT_OFF
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(bmhq_pkg::Depth)) else $error("count overflow");
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("busy overlap");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

/* rtl/bmhq_store.sv */
// Entry store: one write port, one registered read port, key and tag side by side.
// Depends on bmhq_pkg.
`default_nettype none
module bmhq_store (
	input wire logic clk,
	input wire bmhq_pkg::mem_req_t req,
	output logic [bmhq_pkg::KeyWidth-1:0] rkey,
	output logic [bmhq_pkg::TagWidth-1:0] rtag
);
	logic [bmhq_pkg::KeyWidth-1:0] key_mem [bmhq_pkg::Depth];
	logic [bmhq_pkg::TagWidth-1:0] tag_mem [bmhq_pkg::Depth];

	always_ff @(posedge clk) begin
		if (req.we) begin
			key_mem[req.waddr] <= req.wkey;
			tag_mem[req.waddr] <= req.wtag;
		end
		rkey <= key_mem[req.raddr];
		rtag <= tag_mem[req.raddr];
	end
endmodule
`default_nettype wire

/* rtl/bmhq_tag_cam.sv */
// Shadow tag array with a parallel compare for find; lowest matching index wins.
// Depends on bmhq_pkg.
`default_nettype none
module bmhq_tag_cam (
	input wire logic clk,
	input wire logic we,
	input wire logic [bmhq_pkg::AddrWidth-1:0] waddr,
	input wire logic [bmhq_pkg::TagWidth-1:0] wtag,
	input wire logic [bmhq_pkg::TagWidth-1:0] stag,
	input wire logic [bmhq_pkg::CountWidth-1:0] cnt,
	output logic [bmhq_pkg::CountWidth-1:0] hit_idx
);
	logic [bmhq_pkg::TagWidth-1:0] tags_q [bmhq_pkg::Depth];
	logic [bmhq_pkg::Depth-1:0] hit;

	always_ff @(posedge clk) begin
		if (we) tags_q[waddr] <= wtag;
	end

	always_comb begin
		for (int i = 0; i < bmhq_pkg::Depth; i++)
			hit[i] = (tags_q[i] == stag) && (bmhq_pkg::CountWidth'(i) < cnt);
		hit_idx = '0;
		for (int i = bmhq_pkg::Depth - 1; i >= 0; i--)
			if (hit[i]) hit_idx = bmhq_pkg::CountWidth'(i + 1);
	end
endmodule
`default_nettype wire
